[rtl/core/ssa_pkg.sv]
// package for the series sum accumulator: widths, codes, types and
// small double-precision helpers shared by the interfaces and modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic [63:0]      TOL_RESET   = 64'd4532020583610935537;
  localparam logic [63:0]      ONE_BITS    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0]      SIGN_BIT    = 64'h8000_0000_0000_0000;
  localparam logic [63:0]      QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0]      DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE  = 2'd0,
    CFG_TERM_LIMIT = 2'd1,
    CFG_SUM_MODE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_RUNNING   = 2'd0,
    STAT_CONVERGED = 2'd1,
    STAT_LIMIT     = 2'd2,
    STAT_INVALID   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_INVALID,
    KIND_HELD,
    KIND_FWD,
    KIND_KAHAN
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_Y,
    BK_S,
    BK_TMP,
    BK_DIFF,
    BK_COMP,
    BK_FWD,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic [63:0]           tolerance;
    logic [COUNT_BITS-1:0] term_limit;
    logic                  sum_mode;
  } ssa_cfg_t;

  typedef struct packed {
    logic [63:0] term_value;
    logic        first_term;
    logic        invalid;
  } ssa_item_t;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // eps is a magnitude; false whenever either side is nan
  function automatic logic err_above(input logic [63:0] eps, input logic [63:0] tol);
    logic res;
    if (is_nan(eps) || is_nan(tol)) begin
      res = 1'b0;
    end else if (tol[63]) begin
      res = (eps[62:0] != 63'd0) || (tol[62:0] != 63'd0);
    end else begin
      res = eps[62:0] > tol[62:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ssa_if.sv]
// channel interfaces of the series sum accumulator: terms, results and
// register writes; depends on ssa_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ssa_term_if import ssa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] term_value;
  logic        first_term;
  modport source (output valid, term_value, first_term, input ready);
  modport sink   (input valid, term_value, first_term, output ready);
endinterface

interface ssa_res_if import ssa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [63:0]      running_sum;
  logic [1:0]       status;
  logic [63:0]      last_error;
  logic [CNT_W-1:0] terms_used;
  modport source (output valid, running_sum, status, last_error, terms_used, input ready);
  modport sink   (input valid, running_sum, status, last_error, terms_used, output ready);
endinterface

interface ssa_cfg_if import ssa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/ssa_front.sv]
// front end: configuration registers, term intake and tolerance check
// depends on ssa_pkg and ssa_if
`timescale 1ns / 1ps
`default_nettype none
module ssa_front import ssa_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  ssa_term_if.sink    term_i,
  ssa_cfg_if.sink     cfg_i,
  input  wire         q_full_i,
  output logic        push_o,
  output ssa_item_t   item_o,
  output ssa_cfg_t    cfg_o
);

  ssa_cfg_t cfg_q, cfg_d;
  logic     tol_invalid;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TOLERANCE:  cfg_d.tolerance  = cfg_i.data;
        CFG_TERM_LIMIT: cfg_d.term_limit = cfg_i.data[COUNT_BITS-1:0];
        CFG_SUM_MODE:   cfg_d.sum_mode   = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance  <= TOL_RESET;
      cfg_q.term_limit <= LIMIT_RESET;
      cfg_q.sum_mode   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // tolerance >= 1.0 as a double compare, nan never qualifies
  assign tol_invalid = !cfg_q.tolerance[63] && (cfg_q.tolerance[62:0] >= ONE_BITS[62:0]) &&
                       !is_nan(cfg_q.tolerance);

  assign term_i.ready      = !q_full_i;
  assign push_o            = term_i.valid && !q_full_i;
  assign item_o.term_value = term_i.term_value;
  assign item_o.first_term = term_i.first_term;
  assign item_o.invalid    = tol_invalid;
  assign cfg_o             = cfg_q;

endmodule
`default_nettype wire

[rtl/core/ssa_queue.sv]
// two-entry queue of classified terms between front and back end
// depends on ssa_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssa_queue import ssa_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  ssa_item_t  item_i,
  output logic       full_o,
  output logic       valid_o,
  output ssa_item_t  item_o,
  input  wire        pop_i
);

  ssa_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

[rtl/core/ssa_fadd.sv]
// four-stage double-precision adder/subtractor, round to nearest even
// depends on ssa_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssa_fadd import ssa_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [63:0] a_i,
  input  wire  [63:0] b_i,
  input  wire         sub_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [3:0] vld_q;

  // stage 1: specials, swap, align
  logic        bs_eff, a_nan, b_nan, a_inf, b_inf, swap;
  logic        spec_c;
  logic [63:0] spec_val_c;
  logic [63:0] x, y;
  logic        sx, sy;
  logic [10:0] ex, ey, d;
  logic [55:0] mx, my, mask, my_sh;
  logic        sticky;

  logic        s1_spec_q, s1_sign_q, s1_sub_q, s1_zs_q;
  logic [63:0] s1_spec_val_q;
  logic [10:0] s1_e_q;
  logic [55:0] s1_mx_q, s1_my_q;

  always_comb begin
    bs_eff = b_i[63] ^ sub_i;
    a_nan  = is_nan(a_i);
    b_nan  = is_nan(b_i);
    a_inf  = (a_i[62:52] == 11'h7FF) && (a_i[51:0] == 52'd0);
    b_inf  = (b_i[62:52] == 11'h7FF) && (b_i[51:0] == 52'd0);
    spec_c = a_nan || b_nan || a_inf || b_inf;
    if (a_nan)                spec_val_c = a_i | QUIET_BIT;
    else if (b_nan)           spec_val_c = b_i | QUIET_BIT;
    else if (a_inf && b_inf)  spec_val_c = (a_i[63] != bs_eff) ? DEFAULT_NAN : a_i;
    else if (a_inf)           spec_val_c = a_i;
    else                      spec_val_c = {bs_eff, b_i[62:0]};
    swap = b_i[62:0] > a_i[62:0];
    x    = swap ? {bs_eff, b_i[62:0]} : a_i;
    y    = swap ? a_i : {bs_eff, b_i[62:0]};
    sx   = x[63];
    sy   = y[63];
    ex   = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    ey   = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
    mx   = {x[62:52] != 11'd0, x[51:0], 3'b000};
    my   = {y[62:52] != 11'd0, y[51:0], 3'b000};
    d    = ex - ey;
    mask   = (d >= 11'd56) ? {56{1'b1}} : ~({56{1'b1}} << d[5:0]);
    sticky = |(my & mask);
    my_sh  = (d >= 11'd56) ? 56'd0 : (my >> d[5:0]);
    my_sh[0] = my_sh[0] | sticky;
  end

  always_ff @(posedge clk_i) begin
    s1_spec_q     <= spec_c;
    s1_spec_val_q <= spec_val_c;
    s1_sign_q     <= sx;
    s1_sub_q      <= sx ^ sy;
    s1_zs_q       <= sx & sy;
    s1_e_q        <= ex;
    s1_mx_q       <= mx;
    s1_my_q       <= my_sh;
  end

  // stage 2: mantissa add or subtract
  logic        s2_spec_q, s2_sign_q, s2_zs_q;
  logic [63:0] s2_spec_val_q;
  logic [10:0] s2_e_q;
  logic [56:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    s2_spec_q     <= s1_spec_q;
    s2_spec_val_q <= s1_spec_val_q;
    s2_sign_q     <= s1_sign_q;
    s2_zs_q       <= s1_zs_q;
    s2_e_q        <= s1_e_q;
    s2_sum_q      <= s1_sub_q ? ({1'b0, s1_mx_q} - {1'b0, s1_my_q})
                              : ({1'b0, s1_mx_q} + {1'b0, s1_my_q});
  end

  // stage 3: leading zero count and normalise
  logic [5:0]  lz, sh;
  logic [11:0] e_n;
  logic [55:0] n_c;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (s2_sum_q[i]) lz = 6'(55 - i);
    end
    sh  = 6'd0;
    e_n = {1'b0, s2_e_q};
    if (s2_sum_q[56]) begin
      n_c = {s2_sum_q[56:2], s2_sum_q[1] | s2_sum_q[0]};
      e_n = {1'b0, s2_e_q} + 12'd1;
    end else begin
      // stop at the subnormal exponent
      sh  = ({6'd0, lz} > {1'b0, s2_e_q - 11'd1}) ? 6'(s2_e_q - 11'd1) : lz;
      n_c = s2_sum_q[55:0] << sh;
      e_n = {1'b0, s2_e_q} - {6'd0, sh};
    end
  end

  logic        s3_spec_q, s3_sign_q, s3_zero_q, s3_zs_q;
  logic [63:0] s3_spec_val_q;
  logic [11:0] s3_e_q;
  logic [55:0] s3_n_q;

  always_ff @(posedge clk_i) begin
    s3_spec_q     <= s2_spec_q;
    s3_spec_val_q <= s2_spec_val_q;
    s3_sign_q     <= s2_sign_q;
    s3_zs_q       <= s2_zs_q;
    s3_zero_q     <= s2_sum_q == 57'd0;
    s3_e_q        <= e_n;
    s3_n_q        <= n_c;
  end

  // stage 4: round and pack
  logic        rnd_up;
  logic [53:0] mr;
  logic [11:0] e_r;
  logic [63:0] packed_c;

  always_comb begin
    rnd_up = s3_n_q[2] && (s3_n_q[1] || s3_n_q[0] || s3_n_q[3]);
    mr     = {1'b0, s3_n_q[55:3]} + {53'd0, rnd_up};
    e_r    = s3_e_q;
    if (mr[53]) begin
      mr  = mr >> 1;
      e_r = s3_e_q + 12'd1;
    end
    if (s3_spec_q)             packed_c = s3_spec_val_q;
    else if (s3_zero_q)        packed_c = {s3_zs_q, 63'd0};
    else if (e_r >= 12'd2047)  packed_c = {s3_sign_q, 11'h7FF, 52'd0};
    else packed_c = {s3_sign_q, mr[52] ? e_r[10:0] : 11'd0, mr[51:0]};
  end

  always_ff @(posedge clk_i) begin
    res_o <= packed_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 4'd0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  assign done_o = vld_q[3];

endmodule
`default_nettype wire

[rtl/core/ssa_back.sv]
// back end: series state, operation sequencer over the shared adder and
// the result register; depends on ssa_pkg, ssa_if and ssa_fadd
`timescale 1ns / 1ps
`default_nettype none
module ssa_back import ssa_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  ssa_cfg_t    cfg_i,
  input  wire         q_valid_i,
  input  ssa_item_t   q_item_i,
  output logic        pop_o,
  ssa_res_if.source   res_o
);

  bk_state_e        state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [63:0]      accum_q, accum_d, comp_q, comp_d, prev_q, prev_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic [1:0]       hstat_q, hstat_d;
  logic [63:0]      herr_q, herr_d;
  logic [63:0]      term_q, term_d, y_q, y_d, s_q, s_d, tmp_q, tmp_d;
  logic [63:0]      diff_q, diff_d, cnew_q, cnew_d;
  logic             busy_q, busy_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      out_sum_q, out_sum_d, out_err_q, out_err_d;
  logic [1:0]       out_stat_q, out_stat_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;

  logic             add_start, add_done, add_sub;
  logic [63:0]      add_a, add_b, add_res;
  logic [CNT_W-1:0] cnt_inc;
  logic [63:0]      eps;
  logic [1:0]       stat;

  ssa_fadd u_fadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (add_start),
    .a_i     (add_a),
    .b_i     (add_b),
    .sub_i   (add_sub),
    .done_o  (add_done),
    .res_o   (add_res)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.running_sum = out_sum_q;
  assign res_o.status      = out_stat_q;
  assign res_o.last_error  = out_err_q;
  assign res_o.terms_used  = out_cnt_q;

  always_comb begin
    add_a   = accum_q;
    add_b   = term_q;
    add_sub = 1'b0;
    case (state_q)
      BK_Y:    begin add_a = term_q; add_b = comp_q; add_sub = 1'b1; end
      BK_S:    begin add_a = accum_q; add_b = y_q; end
      BK_TMP:  begin add_a = s_q; add_b = accum_q; add_sub = 1'b1; end
      BK_DIFF: begin add_a = prev_q; add_b = s_q; add_sub = 1'b1; end
      BK_COMP: begin add_a = tmp_q; add_b = y_q; add_sub = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    cnt_inc = (cnt_q < COUNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
    if (kind_q == KIND_FWD) begin
      eps = term_q & ~SIGN_BIT;
      if (cnt_inc > {1'b0, cfg_i.term_limit}) stat = STAT_LIMIT;
      else stat = err_above(eps, cfg_i.tolerance) ? STAT_RUNNING : STAT_CONVERGED;
    end else begin
      eps  = diff_q & ~SIGN_BIT;
      stat = err_above(eps, cfg_i.tolerance) ? STAT_RUNNING : STAT_CONVERGED;
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    accum_d     = accum_q;
    comp_d      = comp_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    hstat_d     = hstat_q;
    herr_d      = herr_q;
    term_d      = term_q;
    y_d         = y_q;
    s_d         = s_q;
    tmp_d       = tmp_q;
    diff_d      = diff_q;
    cnew_d      = cnew_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_sum_d   = out_sum_q;
    out_stat_d  = out_stat_q;
    out_err_d   = out_err_q;
    out_cnt_d   = out_cnt_q;
    pop_o       = 1'b0;
    add_start   = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          term_d = q_item_i.term_value;
          if (q_item_i.invalid) begin
            kind_d  = KIND_INVALID;
            state_d = BK_OUT;
          end else begin
            if (q_item_i.first_term) begin
              accum_d = 64'd0;
              comp_d  = 64'd0;
              prev_d  = 64'd0;
              cnt_d   = '0;
              fin_d   = 1'b0;
              hstat_d = STAT_RUNNING;
              herr_d  = 64'd0;
            end
            if (fin_q && !q_item_i.first_term) begin
              kind_d  = KIND_HELD;
              state_d = BK_OUT;
            end else if (cfg_i.sum_mode) begin
              kind_d  = KIND_KAHAN;
              state_d = BK_Y;
            end else begin
              kind_d  = KIND_FWD;
              state_d = BK_FWD;
            end
          end
        end
      end
      BK_Y, BK_S, BK_TMP, BK_DIFF, BK_COMP, BK_FWD: begin
        if (!busy_q) begin
          add_start = 1'b1;
          busy_d    = 1'b1;
        end else if (add_done) begin
          busy_d = 1'b0;
          case (state_q)
            BK_Y:    begin y_d    = add_res; state_d = BK_S;    end
            BK_S:    begin s_d    = add_res; state_d = BK_TMP;  end
            BK_TMP:  begin tmp_d  = add_res; state_d = BK_DIFF; end
            BK_DIFF: begin diff_d = add_res; state_d = BK_COMP; end
            BK_COMP: begin cnew_d = add_res; state_d = BK_OUT;  end
            default: begin s_d    = add_res; state_d = BK_OUT;  end
          endcase
        end
      end
      BK_OUT: begin
        // result register free or being emptied this cycle
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
          case (kind_q)
            KIND_INVALID: begin
              out_sum_d  = accum_q;
              out_stat_d = STAT_INVALID;
              out_err_d  = ONE_BITS;
              out_cnt_d  = cnt_q;
            end
            KIND_HELD: begin
              out_sum_d  = accum_q;
              out_stat_d = hstat_q;
              out_err_d  = herr_q;
              out_cnt_d  = cnt_q;
            end
            default: begin
              accum_d    = s_q;
              prev_d     = s_q;
              if (kind_q == KIND_KAHAN) comp_d = cnew_q;
              cnt_d      = cnt_inc;
              hstat_d    = stat;
              herr_d     = eps;
              fin_d      = stat != STAT_RUNNING;
              out_sum_d  = s_q;
              out_stat_d = stat;
              out_err_d  = eps;
              out_cnt_d  = cnt_inc;
            end
          endcase
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      kind_q      <= KIND_INVALID;
      accum_q     <= 64'd0;
      comp_q      <= 64'd0;
      prev_q      <= 64'd0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      hstat_q     <= STAT_RUNNING;
      herr_q      <= 64'd0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      accum_q     <= accum_d;
      comp_q      <= comp_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      hstat_q     <= hstat_d;
      herr_q      <= herr_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q     <= term_d;
    y_q        <= y_d;
    s_q        <= s_d;
    tmp_q      <= tmp_d;
    diff_q     <= diff_d;
    cnew_q     <= cnew_d;
    out_sum_q  <= out_sum_d;
    out_stat_q <= out_stat_d;
    out_err_q  <= out_err_d;
    out_cnt_q  <= out_cnt_d;
  end

endmodule
`default_nettype wire

[rtl/core/series_sum_accumulator.sv]
// Series sum accumulator, top level.
// term_i carries series terms (double bit patterns) with a first_term flag
// that restarts the series; result_o gives one result per term: running
// sum, status, last error and term count. cfg_i writes the tolerance (0),
// the forward-mode term limit (1) and the summation mode (2); writes are
// taken every cycle and belong between series, with the block idle.
// A front end classifies each term against the tolerance and places it in
// a two-entry queue; the back end works on one term at a time through a
// four-stage double adder and holds the result in an output register.
// A term after the series has finished or with an invalid tolerance
// needs no add, a term in forward mode one add and a term in compensated
// mode five dependent adds. The back end takes the next term from the
// queue only once the last has gone to the output register, as the
// adder is shared and each add waits on the one before.
// Reset restores the register defaults (1e-5, 1000, compensated mode) and
// clears sum, compensation and count. When result_o stalls, the finished
// result waits in its register while the next term is computed, and
// term_i.ready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module series_sum_accumulator import ssa_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  ssa_term_if.sink   term_i,
  ssa_cfg_if.sink    cfg_i,
  ssa_res_if.source  result_o
);

  logic      q_full, q_push, q_valid, q_pop;
  ssa_item_t push_item, head_item;
  ssa_cfg_t  cfg;

  ssa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .term_i   (term_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .item_o   (push_item),
    .cfg_o    (cfg)
  );

  ssa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (q_pop)
  );

  ssa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (head_item),
    .pop_o     (q_pop),
    .res_o     (result_o)
  );

endmodule
`default_nettype wire

[bench/series_sum_accumulator_test.sv]
// self-checking testbench for series_sum_accumulator: drives terms and register
// writes, predicts every result with double arithmetic; needs ssa_pkg, ssa_if
`timescale 1ns / 1ps
module series_sum_accumulator_test;
  import ssa_pkg::*;

  localparam int IDLE_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [63:0]      sum;
    logic [1:0]       status;
    logic [63:0]      err;
    logic [CNT_W-1:0] count;
  } sum_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssa_term_if term_ch ();
  ssa_res_if  res_ch ();
  ssa_cfg_if  cfg_ch ();

  series_sum_accumulator i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .term_i   (term_ch),
    .cfg_i    (cfg_ch),
    .result_o (res_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state and register copy
  logic [63:0]           tol_reg;
  logic [COUNT_BITS-1:0] limit_reg;
  logic                  mode_reg;
  real                   acc_sum, comp_sum, prev_sum;
  logic [CNT_W-1:0]      term_cnt;
  logic                  series_done;
  logic [1:0]            held_stat;
  logic [63:0]           held_err;

  sum_result_t pending_sums[$];
  int          mismatches = 0;
  int          stall_cnt = 0;
  bit          idling_on = 1'b1;
  int          sink_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic real magnitude(real x);
    return $bitstoreal($realtobits(x) & ~SIGN_BIT);
  endfunction

  function automatic void clear_series();
    acc_sum = 0.0;
    comp_sum = 0.0;
    prev_sum = 0.0;
    term_cnt = '0;
    series_done = 1'b0;
    held_stat = STAT_RUNNING;
    held_err = '0;
  endfunction

  function automatic sum_result_t accumulate_term(logic [63:0] tbits, logic first);
    sum_result_t r;
    real tol, t, eps, y, s;
    logic [1:0] st;
    tol = $bitstoreal(tol_reg);
    t = $bitstoreal(tbits);
    if (tol >= 1.0) begin
      r.sum = $realtobits(acc_sum);
      r.status = STAT_INVALID;
      r.err = ONE_BITS;
      r.count = term_cnt;
      return r;
    end
    if (first) clear_series();
    if (!series_done) begin
      if (mode_reg == 1'b0) begin
        acc_sum = acc_sum + t;
        prev_sum = acc_sum;
        eps = magnitude(t);
        if (term_cnt != COUNT_MAX) term_cnt++;
        if (term_cnt > {1'b0, limit_reg}) st = STAT_LIMIT;
        else if (!(eps > tol)) st = STAT_CONVERGED;
        else st = STAT_RUNNING;
      end else begin
        y = t - comp_sum;
        s = acc_sum + y;
        comp_sum = (s - acc_sum) - y;
        eps = magnitude(prev_sum - s);
        prev_sum = s;
        acc_sum = s;
        if (term_cnt != COUNT_MAX) term_cnt++;
        st = (!(eps > tol)) ? STAT_CONVERGED : STAT_RUNNING;
      end
      held_stat = st;
      held_err = $realtobits(eps);
      if (st != STAT_RUNNING) series_done = 1'b1;
    end
    r.sum = $realtobits(acc_sum);
    r.status = held_stat;
    r.err = held_err;
    r.count = term_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // result side: random back-pressure, compare each transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      res_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      res_ch.ready <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    sum_result_t w;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected result", res_ch.running_sum, '0);
      end else begin
        w = pending_sums.pop_front();
        if (res_ch.running_sum !== w.sum) report_mismatch("running_sum", res_ch.running_sum, w.sum);
        if (res_ch.status !== w.status)
          report_mismatch("status", 64'(res_ch.status), 64'(w.status));
        if (res_ch.last_error !== w.err) report_mismatch("last_error", res_ch.last_error, w.err);
        if (res_ch.terms_used !== w.count)
          report_mismatch("terms_used", 64'(res_ch.terms_used), 64'(w.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((term_ch.valid && term_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_term(logic [63:0] tbits, logic first);
    int g;
    @(negedge clk_i);
    term_ch.valid <= 1'b1;
    term_ch.term_value <= tbits;
    term_ch.first_term <= first;
    do @(posedge clk_i); while (!term_ch.ready);
    pending_sums.push_back(accumulate_term(tbits, first));
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      term_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // drains the block before a register write
  task automatic wait_idle();
    @(negedge clk_i);
    term_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_TOLERANCE:  tol_reg = value;
      CFG_TERM_LIMIT: limit_reg = value[COUNT_BITS-1:0];
      default:        mode_reg = value[0];
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [63:0] tol, logic [COUNT_BITS-1:0] lim, logic mode);
    wait_idle();
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_TERM_LIMIT, {48'd0, lim});
    write_reg(CFG_SUM_MODE, {63'd0, mode});
  endtask

  function automatic real rand_unit();
    return real'($urandom) / 4294967296.0;
  endfunction

  task automatic test_reset_defaults();
    send_term($realtobits(1.0), 1'b1);
    send_term($realtobits(0.5), 1'b0);
    send_term($realtobits(1.0e-12), 1'b0);
    send_term($realtobits(7.0), 1'b0);
  endtask

  task automatic test_extremes();
    set_regs($realtobits(1.0e-3), 16'd4, 1'b0);
    send_term(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
    send_term(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_term(64'hFFF0_0000_0000_0000, 1'b1);
    send_term(64'h0000_0000_0000_0001, 1'b1);
    send_term(64'h8000_0000_0000_0000, 1'b1);
    send_term(64'h7FF4_0000_0000_0001, 1'b1);
    // limit reached before the small term converges
    set_regs($realtobits(1.0e-3), 16'd0, 1'b0);
    send_term($realtobits(1.0e-9), 1'b1);
    send_term($realtobits(2.0), 1'b0);
  endtask

  task automatic test_invalid_tolerance();
    set_regs($realtobits(1.0), 16'd10, 1'b1);
    send_term($realtobits(3.0), 1'b1);
    wait_idle();
    write_reg(CFG_TOLERANCE, 64'h7FF0_0000_0000_0000);
    send_term($realtobits(3.0), 1'b0);
    wait_idle();
    write_reg(CFG_TOLERANCE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_term($realtobits(3.0), 1'b1);
    send_term($realtobits(-1.0), 1'b0);
  endtask

  task automatic test_mode_switch();
    set_regs($realtobits(1.0e-8), 16'd65535, 1'b1);
    send_term($realtobits(1.0), 1'b1);
    send_term($realtobits(1.0e-17), 1'b0);
    wait_idle();
    write_reg(CFG_SUM_MODE, 64'd0);
    send_term($realtobits(0.25), 1'b0);
    wait_idle();
    write_reg(CFG_SUM_MODE, 64'd1);
    send_term($realtobits(1.0e-17), 1'b0);
    send_term($realtobits(1.0e-20), 1'b0);
  endtask

  // forward up to the limit, then compensated past it with no gaps
  task automatic test_long_series();
    idling_on = 1'b0;
    set_regs(64'hBFF0_0000_0000_0000, 16'd100, 1'b0);
    send_term(64'd0, 1'b1);
    repeat (99) send_term(64'd0, 1'b0);
    wait_idle();
    write_reg(CFG_SUM_MODE, 64'd1);
    repeat (100) send_term(64'd0, 1'b0);
    idling_on = 1'b1;
  endtask

  task automatic test_random_series();
    int sent, len;
    logic [63:0] tol;
    real a, r, t;
    sent = 0;
    while (sent < 1400) begin
      case ($urandom_range(0, 9))
        0: tol = 64'd0;
        1: tol = {1'b1, 63'($urandom) << 31};
        2: tol = 64'h7FF8_0000_0000_0000;
        3: tol = {$urandom, $urandom};
        default: tol = $realtobits(10.0 ** (-1.0 * $urandom_range(2, 12)));
      endcase
      set_regs(tol, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
               1'($urandom));
      repeat (6) begin
        len = $urandom_range(1, 60);
        a = (rand_unit() - 0.5) * 8.0;
        r = (rand_unit() - 0.5) * 1.8;
        t = a;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) send_term({$urandom, $urandom}, 1'($urandom));
          else send_term($realtobits(t), k == 0);
          t = t * r;
          sent++;
        end
      end
    end
  endtask

  initial begin
    term_ch.valid = 1'b0;
    term_ch.term_value = '0;
    term_ch.first_term = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TOLERANCE;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    tol_reg = TOL_RESET;
    limit_reg = LIMIT_RESET;
    mode_reg = 1'b1;
    clear_series();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_extremes();
    test_invalid_tolerance();
    test_mode_switch();
    test_random_series();
    test_long_series();

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[series_sum_accumulator.f]
rtl/core/ssa_pkg.sv
rtl/core/ssa_if.sv
rtl/core/ssa_front.sv
rtl/core/ssa_queue.sv
rtl/core/ssa_fadd.sv
rtl/core/ssa_back.sv
rtl/core/series_sum_accumulator.sv
bench/series_sum_accumulator_test.sv
